>>> rtl/plbs_pkg.sv
// ----------------------------------------------------------------------------
// plbs_pkg
// Shared constants, types and color helpers for the palette blend scanline
// writer.
// ----------------------------------------------------------------------------
package plbs_pkg;

    localparam int PALETTE_DEPTH = 32768;
    localparam int PAL_AW        = $clog2(PALETTE_DEPTH);
    localparam int MAX_WIDTH     = 512;
    localparam int MAX_HEIGHT    = 256;
    localparam int FRAME_DEPTH   = 2 * MAX_WIDTH * MAX_HEIGHT;
    localparam int FRAME_AW      = $clog2(FRAME_DEPTH);

    localparam logic [1:0] CFG_BLEND    = 2'd0;
    localparam logic [1:0] CFG_SCANLINE = 2'd1;
    localparam logic [1:0] CFG_WIDTH    = 2'd2;
    localparam logic [1:0] CFG_OFFSET   = 2'd3;

    localparam logic CMD_PIXEL   = 1'b0;
    localparam logic CMD_PALETTE = 1'b1;

    localparam logic [9:0]  WIDTH_RESET  = 10'd256;
    localparam logic [31:0] AVG_LSB_MASK = 32'h0101_0101;
    localparam logic [31:0] HALF_MASK    = 32'h00fe_fefe;
    localparam logic [31:0] ALPHA_OPAQUE = 32'hff00_0000;

    typedef struct packed {
        logic [FRAME_AW-1:0] addr;
        logic [8:0]          col;
        logic [8:0]          row;
        logic [31:0]         color;
        logic                last;
    } t_op;

    function automatic logic [31:0] avg32(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] s;
        s = a + b - ((a ^ b) & AVG_LSB_MASK);
        return s >> 1;
    endfunction

    function automatic logic [31:0] half_bright(input logic [31:0] c);
        return ALPHA_OPAQUE | ((c & HALF_MASK) >> 1);
    endfunction

endpackage

>>> rtl/plbs_palette.sv
// ----------------------------------------------------------------------------
// plbs_palette
// Palette store with offset lookup. One write port, one registered read port;
// the read data holds until the next read.
// ----------------------------------------------------------------------------
module plbs_palette
    import plbs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [PAL_AW-1:0] i_wr_addr,
    input  logic [31:0]       i_wr_data,
    input  logic              i_rd_en,
    input  logic [14:0]       i_rd_index,
    input  logic [14:0]       i_offset,
    output logic [31:0]       o_rd_data
);

    logic [31:0]       mem [PALETTE_DEPTH];
    logic [31:0]       r_rd_data;
    logic [15:0]       idx_sum;
    logic [PAL_AW-1:0] rd_addr;

    assign idx_sum   = {1'b0, i_rd_index} + {1'b0, i_offset};
    assign rd_addr   = idx_sum[PAL_AW-1:0];
    assign o_rd_data = r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> rtl/plbs_frame.sv
// ----------------------------------------------------------------------------
// plbs_frame
// Frame store read-modify-write: clear sweep after reset, read stage with
// same-address forwarding, blend, write back and the result register.
// ----------------------------------------------------------------------------
module plbs_frame
    import plbs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_issue,
    input  t_op         i_op,
    input  logic        i_blend,
    input  logic        i_out_stall,
    output logic        o_op_ready,
    output logic        o_clr_busy,
    output logic        o_out_valid,
    output logic [8:0]  o_out_column,
    output logic [8:0]  o_out_row,
    output logic [31:0] o_out_color,
    output logic        o_last
);

    logic [31:0]         mem [FRAME_DEPTH];

    logic                r_clr_busy;
    logic [FRAME_AW-1:0] r_clr_addr;

    logic                r_f_valid;
    t_op                 r_f_op;
    logic [31:0]         r_rdata;
    logic                r_fwd;
    logic [31:0]         r_fwd_data;

    logic                r_o_valid;
    logic [8:0]          r_o_col;
    logic [8:0]          r_o_row;
    logic [31:0]         r_o_color;
    logic                r_o_last;

    logic                out_free;
    logic                adv;
    logic                f_free;
    logic [31:0]         old_val;
    logic [31:0]         new_val;

    assign out_free   = !r_o_valid || !i_out_stall;
    assign adv        = r_f_valid && out_free;
    assign f_free     = !r_f_valid || adv;
    assign old_val    = r_fwd ? r_fwd_data : r_rdata;
    assign new_val    = i_blend ? avg32(old_val, r_f_op.color) : r_f_op.color;

    assign o_op_ready   = f_free;
    assign o_clr_busy   = r_clr_busy;
    assign o_out_valid  = r_o_valid;
    assign o_out_column = r_o_col;
    assign o_out_row    = r_o_row;
    assign o_out_color  = r_o_color;
    assign o_last       = r_o_last;

    // clear sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == FRAME_AW'(FRAME_DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            mem[r_clr_addr] <= '0;
        end else if (adv) begin
            mem[r_f_op.addr] <= new_val;
        end
        if (i_issue) begin
            r_rdata <= mem[i_op.addr];
        end
    end

    // forward a write that lands on the same edge as the read
    always_ff @(posedge i_clk) begin
        if (i_issue) begin
            r_f_op     <= i_op;
            r_fwd      <= adv && (r_f_op.addr == i_op.addr);
            r_fwd_data <= new_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (f_free) begin
                r_f_valid <= i_issue;
            end
            if (out_free) begin
                r_o_valid <= r_f_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_o_col   <= r_f_op.col;
            r_o_row   <= r_f_op.row;
            r_o_color <= new_val;
            r_o_last  <= r_f_op.last;
        end
    end

endmodule

>>> rtl/palette_blend_scanline_writer_core.sv
// ----------------------------------------------------------------------------
// palette_blend_scanline_writer_core
// Palette lookup, optional interframe blend and scanline doubling into a
// frame store, reporting every frame store write.
//
//   channel  direction  handshake                     payload
//   in       input      i_in_valid / o_in_stall       cmd, x, y, index, word
//   out      output     o_out_valid / i_out_stall     column, row, color, last
//   cfg      input      i_cfg_valid / o_cfg_ready     index, data
//
// One item per cycle without scanlines unless the output stalls; with
// scanlines each pixel makes two frame writes, each in one slot of the single
// frame store write port. A pixel passes the pixel, frame read and result
// registers. After reset the frame store is swept to zero, one word per
// cycle; o_in_stall is high meanwhile, config writes are taken. An output
// stall holds the result register and backs up into o_in_stall.
// ----------------------------------------------------------------------------
module palette_blend_scanline_writer_core
    import plbs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_cmd,
    input  logic [8:0]  i_pixel_x,
    input  logic [7:0]  i_pixel_y,
    input  logic [14:0] i_color_index,
    input  logic [31:0] i_palette_word,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [8:0]  o_out_column,
    output logic [8:0]  o_out_row,
    output logic [31:0] o_out_color,
    output logic        o_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [14:0] i_cfg_data
);

    logic        r_blend;
    logic        r_scan;
    logic [9:0]  r_frame_width;
    logic [14:0] r_pal_offset;

    logic        r_p_valid;
    logic        r_p_phase;
    logic [8:0]  r_p_x;
    logic [7:0]  r_p_y;

    logic [9:0]  eff_width;
    logic        in_frame;
    logic        accept;
    logic        pix_go;
    logic        pal_wr;
    logic [31:0] pal_color;
    logic        op_ready;
    logic        clr_busy;
    logic        issue;
    logic        p_free;
    logic [8:0]  row;
    logic [18:0] addr_full;
    t_op         op;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blend       <= 1'b0;
            r_scan        <= 1'b0;
            r_frame_width <= WIDTH_RESET;
            r_pal_offset  <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_BLEND:    r_blend       <= i_cfg_data[0];
                CFG_SCANLINE: r_scan        <= i_cfg_data[0];
                CFG_WIDTH:    r_frame_width <= i_cfg_data[9:0];
                CFG_OFFSET:   r_pal_offset  <= i_cfg_data;
            endcase
        end
    end

    assign eff_width = (r_frame_width > 10'(MAX_WIDTH)) ? 10'(MAX_WIDTH) : r_frame_width;
    assign in_frame  = ({1'b0, i_pixel_x} < eff_width) && ({1'b0, i_pixel_y} < 9'(MAX_HEIGHT));

    assign issue      = r_p_valid && op_ready;
    assign p_free     = !r_p_valid || (op_ready && op.last);
    assign o_in_stall = clr_busy || !p_free;
    assign accept     = i_in_valid && !o_in_stall;
    assign pal_wr     = accept && (i_cmd == CMD_PALETTE);
    assign pix_go     = accept && (i_cmd == CMD_PIXEL) && in_frame;

    plbs_palette u_palette (
        .i_clk      (i_clk),
        .i_wr_en    (pal_wr),
        .i_wr_addr  (i_color_index[PAL_AW-1:0]),
        .i_wr_data  (i_palette_word),
        .i_rd_en    (pix_go),
        .i_rd_index (i_color_index),
        .i_offset   (r_pal_offset),
        .o_rd_data  (pal_color)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_p_phase <= 1'b0;
        end else begin
            if (issue && !op.last) begin
                r_p_phase <= 1'b1;
            end else if (issue) begin
                r_p_phase <= 1'b0;
            end
            if (p_free) begin
                r_p_valid <= pix_go;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pix_go) begin
            r_p_x <= i_pixel_x;
            r_p_y <= i_pixel_y;
        end
    end

    assign row       = r_scan ? {r_p_y, r_p_phase} : {1'b0, r_p_y};
    assign addr_full = 19'(row) * 19'(eff_width) + 19'(r_p_x);

    always_comb begin
        op.addr  = addr_full[FRAME_AW-1:0];
        op.col   = r_p_x;
        op.row   = row;
        op.color = r_p_phase ? half_bright(pal_color) : pal_color;
        op.last  = !r_scan || r_p_phase;
    end

    plbs_frame u_frame (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_issue      (issue),
        .i_op         (op),
        .i_blend      (r_blend),
        .i_out_stall  (i_out_stall),
        .o_op_ready   (op_ready),
        .o_clr_busy   (clr_busy),
        .o_out_valid  (o_out_valid),
        .o_out_column (o_out_column),
        .o_out_row    (o_out_row),
        .o_out_color  (o_out_color),
        .o_last       (o_last)
    );

endmodule

>>> rtl/plbs_checker.sv
// ----------------------------------------------------------------------------
// plbs_checker
// Port-level checks for the palette blend scanline writer.
// ----------------------------------------------------------------------------
module plbs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [8:0]  o_out_column,
    input logic [8:0]  o_out_row,
    input logic [31:0] o_out_color,
    input logic        o_last
);

    // clear sweep blocks input right after reset
    a_reset_stall: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("input not stalled during frame clear");

    // first write of a doubled row pair is on the even row
    a_pair_even: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last |-> o_out_row[0] == 1'b0)
        else $error("non-final write on odd row");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_color) && $stable(o_out_row)
            && $stable(o_out_column) && $stable(o_last))
        else $error("stalled result changed");

endmodule

bind palette_blend_scanline_writer_core plbs_checker u_plbs_checker (.*);

>>> tb/sv/palette_blend_scanline_writer_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palette_blend_scanline_writer_core_test
// Self-checking bench for the palette blend scanline writer. A clocked driver
// feeds palette loads and pixels from a queue; a clocked monitor keeps its own
// palette and frame store, predicts every frame write and checks each output
// transfer in order. Runs directed corner cases, then random phases with
// random register settings and random gaps and output stalls.
// ----------------------------------------------------------------------------
module palette_blend_scanline_writer_core_test;
    import plbs_pkg::*;

    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 125;
    localparam int QUIET_LIMIT     = 800000;
    localparam int SETTLE_CYCLES   = 8;
    localparam int MAX_REPORTS     = 100;

    typedef struct {
        logic        cmd;
        logic [8:0]  x;
        logic [7:0]  y;
        logic [14:0] index;
        logic [31:0] word;
    } t_draw_cmd;

    typedef struct {
        logic [8:0]  column;
        logic [8:0]  row;
        logic [31:0] color;
        logic        last;
    } t_frame_write;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_in_valid     = 1'b0;
    logic        o_in_stall;
    logic        i_cmd          = CMD_PIXEL;
    logic [8:0]  i_pixel_x      = '0;
    logic [7:0]  i_pixel_y      = '0;
    logic [14:0] i_color_index  = '0;
    logic [31:0] i_palette_word = '0;
    logic        o_out_valid;
    logic        i_out_stall    = 1'b0;
    logic [8:0]  o_out_column;
    logic [8:0]  o_out_row;
    logic [31:0] o_out_color;
    logic        o_last;
    logic        i_cfg_valid    = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index    = CFG_BLEND;
    logic [14:0] i_cfg_data     = '0;

    t_draw_cmd    pending_draw_cmds[$];
    t_draw_cmd    next_cmd;
    t_frame_write expected_writes[$];
    logic [14:0]  loaded_entries[$];

    bit [31:0]    palette_mem[PALETTE_DEPTH];
    bit [31:0]    frame_mem[FRAME_DEPTH];

    logic         shadow_blend  = 1'b0;
    logic         shadow_scan   = 1'b0;
    logic [9:0]   shadow_width  = WIDTH_RESET;
    logic [14:0]  shadow_offset = '0;

    int           gen_width;
    logic [14:0]  gen_offset;
    logic         no_gaps       = 1'b0;
    logic         cmd_taken     = 1'b0;
    int           quiet_cycles  = 0;
    int           mismatch_count = 0;

    palette_blend_scanline_writer_core DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_cmd          (i_cmd),
        .i_pixel_x      (i_pixel_x),
        .i_pixel_y      (i_pixel_y),
        .i_color_index  (i_color_index),
        .i_palette_word (i_palette_word),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_column   (o_out_column),
        .o_out_row      (o_out_row),
        .o_out_color    (o_out_color),
        .o_last         (o_last),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("ERROR at %0t: %s", $realtime, msg);
        end
    endtask

    function automatic logic [31:0] mix_colors(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] sum;
        sum = a + b - ((a ^ b) & 32'h0101_0101);
        return sum >> 1;
    endfunction

    task automatic store_pixel(input int row, input int col, input int width,
                               input logic [31:0] color, input logic last);
        int           addr;
        t_frame_write w;
        addr = (row * width + col) % FRAME_DEPTH;
        w.color = shadow_blend ? mix_colors(frame_mem[addr], color) : color;
        frame_mem[addr] = w.color;
        w.column = col[8:0];
        w.row    = row[8:0];
        w.last   = last;
        expected_writes.push_back(w);
    endtask

    task automatic predict_frame_writes(input logic [8:0] x, input logic [7:0] y,
                                        input logic [14:0] index);
        int          width;
        logic [31:0] color;
        width = (shadow_width > MAX_WIDTH) ? MAX_WIDTH : int'(shadow_width);
        if (int'(x) >= width || int'(y) >= MAX_HEIGHT) return;
        color = palette_mem[(int'(index) + int'(shadow_offset)) % PALETTE_DEPTH];
        if (!shadow_scan) begin
            store_pixel(int'(y), int'(x), width, color, 1'b1);
        end else begin
            store_pixel(2 * int'(y), int'(x), width, color, 1'b0);
            store_pixel(2 * int'(y) + 1, int'(x), width,
                        32'hff00_0000 | ((color & 32'h00fe_fefe) >> 1), 1'b1);
        end
    endtask

    task automatic check_frame_write();
        t_frame_write w;
        if (expected_writes.size() == 0) begin
            report_mismatch($sformatf("unexpected write col %0d row %0d color %08h",
                                      o_out_column, o_out_row, o_out_color));
            return;
        end
        w = expected_writes.pop_front();
        if (o_out_column !== w.column)
            report_mismatch($sformatf("column %0d, expected %0d", o_out_column, w.column));
        if (o_out_row !== w.row)
            report_mismatch($sformatf("row %0d, expected %0d", o_out_row, w.row));
        if (o_out_color !== w.color)
            report_mismatch($sformatf("color %08h, expected %08h at col %0d row %0d",
                                      o_out_color, w.color, w.column, w.row));
        if (o_last !== w.last)
            report_mismatch($sformatf("last %0b, expected %0b", o_last, w.last));
    endtask

    // monitor: predictor update on input transfers, checks on output transfers
    always @(posedge i_clk) begin
        cmd_taken <= i_in_valid && !o_in_stall;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                if (i_cmd == CMD_PALETTE) begin
                    palette_mem[i_color_index] = i_palette_word;
                end else begin
                    predict_frame_writes(i_pixel_x, i_pixel_y, i_color_index);
                end
            end
            if (o_out_valid && !i_out_stall) begin
                check_frame_write();
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_BLEND:    shadow_blend  = i_cfg_data[0];
                    CFG_SCANLINE: shadow_scan   = i_cfg_data[0];
                    CFG_WIDTH:    shadow_width  = i_cfg_data[9:0];
                    CFG_OFFSET:   shadow_offset = i_cfg_data;
                    default: ;
                endcase
            end
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // driver
    always @(negedge i_clk) begin
        if (!i_in_valid || cmd_taken) begin
            if (i_rst_n && pending_draw_cmds.size() != 0 &&
                (no_gaps || $urandom_range(99) >= 18)) begin
                next_cmd = pending_draw_cmds.pop_front();
                i_in_valid     <= 1'b1;
                i_cmd          <= next_cmd.cmd;
                i_pixel_x      <= next_cmd.x;
                i_pixel_y      <= next_cmd.y;
                i_color_index  <= next_cmd.index;
                i_palette_word <= next_cmd.word;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        i_out_stall <= !no_gaps && ($urandom_range(99) < 18);
    end

    task automatic write_reg(input logic [1:0] index, input logic [14:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_mode(input logic blend, input logic scan, input logic [9:0] width,
                            input logic [14:0] offset);
        write_reg(CFG_BLEND, {14'd0, blend});
        write_reg(CFG_SCANLINE, {14'd0, scan});
        write_reg(CFG_WIDTH, {5'd0, width});
        write_reg(CFG_OFFSET, offset);
        gen_width  = int'(width);
        gen_offset = offset;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        do @(posedge i_clk);
        while (pending_draw_cmds.size() != 0 || i_in_valid || expected_writes.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic queue_palette(input logic [14:0] entry, input logic [31:0] word);
        t_draw_cmd c;
        c.cmd   = CMD_PALETTE;
        c.x     = 9'($urandom_range(511));
        c.y     = 8'($urandom_range(255));
        c.index = entry;
        c.word  = word;
        pending_draw_cmds.push_back(c);
        loaded_entries.push_back(entry);
    endtask

    // index chosen so that index + offset lands on the given palette entry
    task automatic queue_pixel(input logic [8:0] x, input logic [7:0] y,
                               input logic [14:0] entry);
        t_draw_cmd c;
        c.cmd   = CMD_PIXEL;
        c.x     = x;
        c.y     = y;
        c.index = entry - gen_offset;
        c.word  = $urandom();
        pending_draw_cmds.push_back(c);
    endtask

    task automatic queue_random_cmd();
        int          eff;
        int          pick;
        logic [8:0]  x;
        logic [7:0]  y;
        if ($urandom_range(99) < 20) begin
            queue_palette(15'($urandom_range(32767)), $urandom());
            return;
        end
        eff  = (gen_width > MAX_WIDTH) ? MAX_WIDTH : gen_width;
        pick = $urandom_range(99);
        if (eff == 0 || pick < 10) begin
            x = 9'($urandom_range(511));
        end else if (pick < 40) begin
            x = 9'($urandom_range(((eff < 8) ? eff : 8) - 1));
        end else begin
            x = 9'($urandom_range(eff - 1));
        end
        y = ($urandom_range(99) < 30) ? 8'($urandom_range(3)) : 8'($urandom_range(255));
        queue_pixel(x, y, loaded_entries[$urandom_range(loaded_entries.size() - 1)]);
    endtask

    initial begin
        logic [9:0]  width;
        logic [14:0] offset;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed corners
        set_mode(1'b0, 1'b0, 10'd256, 15'd0);
        queue_palette(15'h0000, 32'hffff_ffff);
        queue_palette(15'h7fff, 32'h0000_0000);
        queue_palette(15'h2aaa, 32'h80ff_01fe);
        queue_palette(15'h5555, 32'h7f00_fe01);
        queue_pixel(9'd0, 8'd0, 15'h0000);
        queue_pixel(9'd255, 8'd255, 15'h7fff);
        queue_pixel(9'd256, 8'd0, 15'h0000);
        queue_pixel(9'd511, 8'd255, 15'h2aaa);
        wait_drained();

        // oversized width, max offset with index wrap, blend + scanlines
        set_mode(1'b1, 1'b1, 10'd1023, 15'h7fff);
        queue_pixel(9'd511, 8'd255, 15'h2aaa);
        queue_pixel(9'd511, 8'd255, 15'h5555);
        queue_pixel(9'd0, 8'd0, 15'h7fff);
        wait_drained();

        // zero width: nothing lands
        set_mode(1'b0, 1'b0, 10'd0, 15'd0);
        queue_pixel(9'd0, 8'd0, 15'h0000);
        queue_palette(15'h0001, 32'h0101_0101);
        wait_drained();

        set_mode(1'b1, 1'b0, 10'd1, 15'd12345);
        queue_pixel(9'd0, 8'd0, 15'h0001);
        queue_pixel(9'd1, 8'd0, 15'h0001);
        queue_pixel(9'd0, 8'd255, 15'h2aaa);
        wait_drained();

        // same store seen through a new width mapping
        set_mode(1'b1, 1'b0, 10'd512, 15'd0);
        queue_pixel(9'd511, 8'd255, 15'h5555);
        queue_pixel(9'd0, 8'd1, 15'h0000);
        wait_drained();

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case ($urandom_range(9))
                0:       width = 10'd1;
                1:       width = 10'd512;
                2:       width = 10'd0;
                3:       width = 10'($urandom_range(1023, 513));
                default: width = 10'($urandom_range(512, 1));
            endcase
            case ($urandom_range(3))
                0:       offset = 15'd0;
                1:       offset = 15'h7fff;
                default: offset = 15'($urandom_range(32767));
            endcase
            set_mode(1'($urandom_range(1)), 1'($urandom_range(1)), width, offset);
            no_gaps = (phase == 3);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                queue_random_cmd();
            end
            wait_drained();
            no_gaps = 1'b0;
        end

        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
